// ===== rtl/newton_square_root_macros.svh =====
// Assertion macros for the square root block checker.
// Included by the checker file only; depends on nothing else.
`ifndef NEWTON_SQUARE_ROOT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_MACROS_SVH

// Overlapping implication, checked on the rising clock edge, off during reset.
`define NSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication that is checked in the cycle after the antecedent.
`define NSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nsq_pkg.sv =====
// Shared types, constants and the microcode program of the square root block.
// Depends on nothing; used by the top level and the interface file.
package nsq_pkg;

  localparam int unsigned DATA_WIDTH_DEFAULT = 32;
  localparam int unsigned FRAC_BITS_DEFAULT  = 16;
  localparam int unsigned ITER_WIDTH         = 6;
  localparam logic [ITER_WIDTH-1:0] ITER_RESET = 6'd5;

  localparam int unsigned STEP_WIDTH = 3;
  typedef logic [STEP_WIDTH-1:0] step_t;

  // Program addresses.
  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_DIV_INIT = 3'd1;
  localparam step_t STEP_DIV      = 3'd2;
  localparam step_t STEP_UPDATE   = 3'd3;
  localparam step_t STEP_EMIT     = 3'd4;

  typedef enum logic [2:0] {
    UOP_LOAD,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_UPDATE,
    UOP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_X_ZERO,
    COND_DIV_MORE,
    COND_MORE_STEPS,
    COND_OUT_BUSY
  } cond_t;

  // One control word: the operation, the jump condition, the target taken
  // when the condition holds, and the target taken otherwise.
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t jump;
    step_t next;
  } ucode_word_t;

  function automatic ucode_word_t ucode_rom(input step_t step);
    ucode_word_t w;
    case (step)
      STEP_IDLE:     w = '{UOP_LOAD,     COND_NO_INPUT,   STEP_IDLE,     STEP_DIV_INIT};
      STEP_DIV_INIT: w = '{UOP_DIV_INIT, COND_X_ZERO,     STEP_UPDATE,   STEP_DIV};
      STEP_DIV:      w = '{UOP_DIV_STEP, COND_DIV_MORE,   STEP_DIV,      STEP_UPDATE};
      STEP_UPDATE:   w = '{UOP_UPDATE,   COND_MORE_STEPS, STEP_DIV_INIT, STEP_EMIT};
      STEP_EMIT:     w = '{UOP_EMIT,     COND_OUT_BUSY,   STEP_EMIT,     STEP_IDLE};
      default:       w = '{UOP_LOAD,     COND_NEVER,      STEP_IDLE,     STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/nsq_if.sv =====
// Channel interfaces of the square root block: radicand in, root out, config.
// Depends on nsq_pkg for default widths.
interface nsq_req_if #(
  parameter int unsigned DATA_WIDTH = nsq_pkg::DATA_WIDTH_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface nsq_rsp_if #(
  parameter int unsigned DATA_WIDTH = nsq_pkg::DATA_WIDTH_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

interface nsq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nsq_pkg::ITER_WIDTH-1:0]  iterations;

  modport source (output valid, output iterations, input ready);
  modport sink   (input valid, input iterations, output ready);
endinterface

// ===== rtl/newton_square_root.sv =====
// Channel   Direction  Payload            Transaction
// req       in         radicand (Q16.16)  one radicand to take the root of
// rsp       out        root (Q16.16)      one square root estimate
// cfg       in         iterations         write of the extra step count
//
// Each of the iterations + 1 Newton steps runs the restoring divider at one quotient bit
// a cycle over DATA_WIDTH + FRAC_BITS bits; a step from a zero estimate skips the division.
// Reset (synchronous, active high) returns the sequencer to idle, clears the output
// valid and sets iterations to 5. A finished root waits in the output register while
// the next radicand is accepted; the sequencer only stalls when it must emit again.
//
// Depends on nsq_pkg and the interfaces in nsq_if.sv.
module newton_square_root #(
  parameter int unsigned DATA_WIDTH = nsq_pkg::DATA_WIDTH_DEFAULT,
  parameter int unsigned FRAC_BITS  = nsq_pkg::FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  nsq_req_if.sink   req,
  nsq_rsp_if.source rsp,
  nsq_cfg_if.sink   cfg
);

  // The division runs over the radicand followed by FRAC_BITS zero bits.
  localparam int unsigned TOTAL    = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned BITCNT_W = $clog2(TOTAL);
  // The seed sum 1.0 + a needs room for both terms plus a carry.
  localparam int unsigned SEED_W   = TOTAL + 1;
  localparam logic [SEED_W-1:0] ONE_FIXED = SEED_W'(1) << FRAC_BITS;

  // Microcode sequencer.
  nsq_pkg::step_t       pc;
  nsq_pkg::step_t       pc_next;
  nsq_pkg::ucode_word_t word;
  logic                 cond_true;

  // Datapath registers.
  logic [nsq_pkg::ITER_WIDTH-1:0] iterations;
  logic [nsq_pkg::ITER_WIDTH-1:0] step_count;
  logic [DATA_WIDTH-1:0]          radicand;
  logic [DATA_WIDTH-1:0]          estimate;
  logic [DATA_WIDTH-1:0]          rem;
  logic [DATA_WIDTH-1:0]          quo;
  logic                           sat;
  logic [TOTAL-1:0]               dividend;
  logic [BITCNT_W-1:0]            bit_count;
  logic [DATA_WIDTH-1:0]          result;
  logic                           out_valid;

  // Combinational datapath values.
  logic                  out_busy;
  logic                  load_fire;
  logic                  emit_fire;
  logic [SEED_W-1:0]     seed_sum;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH:0]   heron_sum;

  assign word = nsq_pkg::ucode_rom(pc);

  // Jump conditions of the program.
  always_comb begin
    case (word.cond)
      nsq_pkg::COND_NEVER:      cond_true = 1'b0;
      nsq_pkg::COND_NO_INPUT:   cond_true = !req.valid;
      nsq_pkg::COND_X_ZERO:     cond_true = (estimate == '0);
      nsq_pkg::COND_DIV_MORE:   cond_true = (bit_count != '0);
      nsq_pkg::COND_MORE_STEPS: cond_true = (step_count < iterations);
      nsq_pkg::COND_OUT_BUSY:   cond_true = out_busy;
      default:                  cond_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = cond_true ? word.jump : word.next;
  end

  // Handshake outputs and operation strobes.
  always_comb begin
    out_busy  = out_valid && !rsp.ready;
    req.ready = (word.op == nsq_pkg::UOP_LOAD);
    load_fire = req.valid && (word.op == nsq_pkg::UOP_LOAD);
    emit_fire = (word.op == nsq_pkg::UOP_EMIT) && !out_busy;
    rsp.valid = out_valid;
    rsp.root  = result;
    cfg.ready = 1'b1;
  end

  // Arithmetic: seed, one restoring division step, and the Heron average.
  always_comb begin
    seed_sum  = ONE_FIXED + SEED_W'(req.radicand);
    shifted   = {rem, dividend[TOTAL-1]};
    diff      = shifted - {1'b0, estimate};
    ge        = (shifted >= {1'b0, estimate});
    quotient  = sat ? '1 : quo;
    heron_sum = {1'b0, estimate} + {1'b0, quotient};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= nsq_pkg::STEP_IDLE;
      out_valid  <= 1'b0;
      iterations <= nsq_pkg::ITER_RESET;
      step_count <= '0;
      estimate   <= '0;
    end else begin
      pc <= pc_next;
      if (cfg.valid) begin
        iterations <= cfg.iterations;
      end
      if (out_valid && rsp.ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      case (word.op)
        nsq_pkg::UOP_LOAD: begin
          if (load_fire) begin
            radicand   <= req.radicand;
            estimate   <= seed_sum[DATA_WIDTH:1];
            step_count <= '0;
          end
        end
        nsq_pkg::UOP_DIV_INIT: begin
          rem       <= '0;
          quo       <= '0;
          sat       <= 1'b0;
          dividend  <= TOTAL'(radicand) << FRAC_BITS;
          bit_count <= BITCNT_W'(TOTAL - 1);
        end
        nsq_pkg::UOP_DIV_STEP: begin
          rem       <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
          // A quotient that outgrows the word saturates to all ones.
          if (quo[DATA_WIDTH-1]) begin
            sat <= 1'b1;
          end
          quo       <= {quo[DATA_WIDTH-2:0], ge};
          dividend  <= dividend << 1;
          bit_count <= bit_count - 1'b1;
        end
        nsq_pkg::UOP_UPDATE: begin
          estimate <= heron_sum[DATA_WIDTH:1];
          if (step_count < iterations) begin
            step_count <= step_count + 1'b1;
          end
        end
        nsq_pkg::UOP_EMIT: begin
          if (emit_fire) begin
            result    <= estimate;
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/nsq_checker.sv =====
// Port-level checker for the square root block, bound to its top level.
// Depends on newton_square_root_macros.svh and the top level's ports.
`include "newton_square_root_macros.svh"

module nsq_checker #(
  parameter int unsigned DATA_WIDTH = nsq_pkg::DATA_WIDTH_DEFAULT
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [DATA_WIDTH-1:0] rsp_root
);

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] pending;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Items accepted whose root has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_fire && !rsp_fire) begin
      pending <= pending + 1'b1;
    end else if (rsp_fire && !req_fire) begin
      pending <= pending - 1'b1;
    end
  end

  `NSQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_root), "root changed or dropped while stalled")
  `NSQ_ASSERT_NOW(a_no_phantom, clk, rst, rsp_valid, pending != 2'd0, "root shown with no radicand outstanding")
  `NSQ_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_fire, !req_ready, "radicand taken in the cycle after another")
  `NSQ_ASSERT_NOW(a_depth, clk, rst, pending == 2'd2, !req_ready, "more than two transactions in flight")

endmodule

bind newton_square_root nsq_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_nsq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_root  (rsp.root)
);

// ===== tb/tb_newton_square_root.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the newton_square_root block: a result scoreboard and the top.
// Depends on nsq_pkg, the channel interfaces in nsq_if.sv and the newton_square_root RTL.

class root_scoreboard;
  logic [31:0] expected_roots[$];
  logic [nsq_pkg::ITER_WIDTH-1:0] iterations;
  int mismatches;

  function new();
    iterations = nsq_pkg::ITER_RESET;
    mismatches = 0;
  endfunction

  function void set_iterations(input logic [nsq_pkg::ITER_WIDTH-1:0] n);
    iterations = n;
  endfunction

  function int pending();
    return expected_roots.size();
  endfunction

  // Heron's method in Q16.16: start at (1 + a) / 2, then extra + 1 steps of
  // x = (x + a / x) / 2 with a truncating divide and a 33-bit sum.
  static function logic [31:0] heron_root(input logic [31:0] a,
                                          input logic [nsq_pkg::ITER_WIDTH-1:0] extra);
    logic [32:0] x;
    logic [63:0] quot;
    logic [31:0] q;
    x = ({1'b0, 32'h0001_0000} + {1'b0, a}) >> 1;
    for (int k = 0; k <= int'(extra); k++) begin
      if (x == 33'd0) begin
        q = 32'd0;
      end else begin
        quot = ({32'd0, a} << nsq_pkg::FRAC_BITS_DEFAULT) / {31'd0, x};
        q = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
      end
      x = ({1'b0, x[31:0]} + {1'b0, q}) >> 1;
    end
    return x[31:0];
  endfunction

  function void note_radicand(input logic [31:0] a);
    expected_roots.push_back(heron_root(a, iterations));
  endfunction

  task report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_root(input logic [31:0] got);
    logic [31:0] want;
    if (expected_roots.size() == 0) begin
      report_mismatch($sformatf("root %h with no radicand outstanding", got));
    end else begin
      want = expected_roots.pop_front();
      if (got !== want) report_mismatch($sformatf("root %h, expected %h", got, want));
    end
  endtask
endclass

module tb_newton_square_root;

  // The limit is sized for the slowest correct run: 20 directed items at 5 steps,
  // 12 items at 63 steps and the rest at 0 to 10 steps, each item also paying
  // random idle gaps on both channels.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int NUM_PHASES  = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  nsq_req_if req_ch ();
  nsq_rsp_if rsp_ch ();
  nsq_cfg_if cfg_ch ();

  newton_square_root dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  root_scoreboard roots = new();

  // When set, the corresponding side inserts no idle cycles, giving stretches of
  // back-to-back traffic between the randomly throttled stretches.
  bit req_eager = 1'b0;
  bit rsp_eager = 1'b0;

  // Current step setting, used to size the quiet period at the end.
  logic [nsq_pkg::ITER_WIDTH-1:0] cur_iter = nsq_pkg::ITER_RESET;

  int cycles = 0;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Every accepted root transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) roots.check_root(rsp_ch.root);
  end

  // Result side: before each result it holds ready low for a random stall, then
  // keeps ready high until a root transaction completes.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rsp_eager ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Presents one radicand after a random gap and returns once the transaction
  // is accepted. Valid stays high on return so that back-to-back items never
  // lower and raise it in the same time step.
  task automatic send_radicand(input logic [31:0] a);
    int gap;
    gap = req_eager ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.radicand <= a;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    roots.note_radicand(a);
  endtask

  // Writes the step count once the block has drained every outstanding root.
  // Each item yields exactly one root, so an empty scoreboard means idle.
  task automatic write_iterations(input logic [nsq_pkg::ITER_WIDTH-1:0] n);
    while (roots.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.iterations <= n;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    roots.set_iterations(n);
    cur_iter = n;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random radicands weighted toward the interesting regions: zero and tiny
  // values (the zero-estimate path), values near 1.0, single bits, exact
  // squares, the top of the range, and plain full-range words.
  function automatic logic [31:0] draw_radicand();
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0:       return 32'($urandom_range(0, 3));
      1, 2:    return 32'($urandom_range(0, 32'h0003_FFFF));
      3:       return 32'd1 << $urandom_range(0, 31);
      4: begin
        k = 32'($urandom_range(0, 255));
        return (k * k) << nsq_pkg::FRAC_BITS_DEFAULT;
      end
      5:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] directed[20];
    // Step settings per random phase: both extremes, the smallest nonzero one,
    // the reset value written explicitly, and two random middle settings.
    int phase_iter[NUM_PHASES];
    int phase_items[NUM_PHASES];

    directed = '{
      32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'h0000_0100, 32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001,
      32'h0002_0000, 32'h0004_0000, 32'h0009_0000, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    phase_items = '{200, 12, 200, 150, 150, 138};
    phase_iter = '{0, 63, 1, $urandom_range(2, 10), 5, $urandom_range(2, 10)};

    req_ch.valid      = 1'b0;
    req_ch.radicand   = 32'd0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.iterations = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items run at the reset step count, which is itself under test.
    foreach (directed[i]) send_radicand(directed[i]);
    @(negedge clk);
    req_ch.valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_iterations(phase_iter[p][nsq_pkg::ITER_WIDTH-1:0]);
      for (int i = 0; i < phase_items[p]; i++) begin
        // Redraw the throttling mode now and then so that quiet and busy
        // stretches both occur on each side.
        if (i % 40 == 0) begin
          req_eager = ($urandom_range(0, 3) == 0);
          rsp_eager = ($urandom_range(0, 3) == 0);
        end
        send_radicand(draw_radicand());
      end
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end

    // Drain, then stay quiet for one full item time to catch stray roots.
    while (roots.pending() != 0) @(posedge clk);
    repeat (2 + (int'(cur_iter) + 1) * 50 + 20) @(posedge clk);

    if (roots.mismatches == 0 && roots.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/nsq_pkg.sv
rtl/nsq_if.sv
rtl/newton_square_root.sv
rtl/nsq_checker.sv
tb/tb_newton_square_root.sv
